// ===== sv/b64e_pkg.sv =====
package b64e_pkg;

  localparam int DATA_W       = 8;
  localparam int CHAR_W       = 7;
  localparam int CHARS_PER_GRP = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

  // Hold counts of the front end.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef logic [CHAR_W-1:0] char_t;

  // One encoded group: four characters, first in slot 0, and the end flag.
  typedef struct packed {
    char_t [CHARS_PER_GRP-1:0] chars;
    logic                      fin;
  } grp_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic char_t sextet_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ===== sv/b64e_if.sv =====
// Byte input channel.
interface b64e_in_if;
  logic                         valid;
  logic                         ready;
  logic [b64e_pkg::DATA_W-1:0]  data_byte;
  logic                         final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Character output channel.
interface b64e_out_if;
  logic                         valid;
  logic                         ready;
  logic [b64e_pkg::CHAR_W-1:0]  out_char;
  logic                         last_of_run;
  logic                         end_of_text;

  modport source (output valid, output out_char, output last_of_run, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_char, input last_of_run, input end_of_text,
                  output ready);
endinterface

// ===== sv/b64e_front.sv =====
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  b64e_in_if.sink           in_ch,
  input  b64e_pkg::q_stat_t q_stat,
  output logic              push,
  output b64e_pkg::grp_t    push_grp
);
  import b64e_pkg::*;

  logic [15:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_cnt_r, held_cnt_nxt;

  logic [1:0]  cnt;
  logic [7:0]  b, b0, b1;
  logic        fin, xfer, emit;

  assign cnt  = (held_cnt_r == 2'd3) ? HELD_NONE : held_cnt_r;
  assign b    = in_ch.data_byte;
  assign fin  = in_ch.final_byte;
  assign b0   = held_bytes_r[15:8];
  assign b1   = held_bytes_r[7:0];

  assign in_ch.ready = !q_stat.full;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign emit        = (cnt == HELD_TWO) || fin;
  assign push        = xfer && emit;

  // Build the four characters of the group this byte completes.
  always_comb begin
    push_grp.fin = fin;
    unique case (cnt)
      HELD_TWO: begin
        push_grp.chars[0] = sextet_char(b0[7:2]);
        push_grp.chars[1] = sextet_char({b0[1:0], b1[7:4]});
        push_grp.chars[2] = sextet_char({b1[3:0], b[7:6]});
        push_grp.chars[3] = sextet_char(b[5:0]);
      end
      HELD_ONE: begin
        push_grp.chars[0] = sextet_char(b0[7:2]);
        push_grp.chars[1] = sextet_char({b0[1:0], b[7:4]});
        push_grp.chars[2] = sextet_char({b[3:0], 2'b00});
        push_grp.chars[3] = PAD_CHAR;
      end
      default: begin
        push_grp.chars[0] = sextet_char(b[7:2]);
        push_grp.chars[1] = sextet_char({b[1:0], 4'b0000});
        push_grp.chars[2] = PAD_CHAR;
        push_grp.chars[3] = PAD_CHAR;
      end
    endcase
  end

  // Store pending bytes; a completed group or a final byte empties the hold.
  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_cnt_nxt   = held_cnt_r;
    if (xfer) begin
      if (emit) begin
        held_bytes_nxt = 16'h0000;
        held_cnt_nxt   = HELD_NONE;
      end else if (cnt == HELD_NONE) begin
        held_bytes_nxt = {b, 8'h00};
        held_cnt_nxt   = HELD_ONE;
      end else begin
        held_bytes_nxt = {b0, b};
        held_cnt_nxt   = HELD_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= 16'h0000;
      held_cnt_r   <= HELD_NONE;
    end else begin
      held_bytes_r <= held_bytes_nxt;
      held_cnt_r   <= held_cnt_nxt;
    end
  end

endmodule

// ===== sv/b64e_queue.sv =====
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::grp_t    push_grp,
  input  logic              pop,
  output b64e_pkg::grp_t    head,
  output b64e_pkg::q_stat_t q_stat
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = entry_r[rd_ptr_r];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_grp;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64e_back.sv =====
module b64e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64e_pkg::grp_t    head,
  input  b64e_pkg::q_stat_t q_stat,
  output logic              pop,
  b64e_out_if.source        out_ch
);
  import b64e_pkg::*;

  localparam int IDX_W = $clog2(CHARS_PER_GRP);

  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  char_t            out_char_r;
  logic             last_r, eot_r;

  logic             load, last_char;

  assign load      = (!out_valid_r || out_ch.ready) && !q_stat.empty;
  assign last_char = (idx_r == IDX_W'(CHARS_PER_GRP - 1));
  assign pop       = load && last_char;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.end_of_text = eot_r;

  // Character index within the head group and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= last_char ? '0 : idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= head.chars[idx_r];
      last_r     <= last_char;
      eot_r      <= last_char && head.fin;
    end
  end

endmodule

// ===== sv/base64_encode_bytes_unit.sv =====
// Channel   Dir  Payload                                  Transfer
// in_ch     in   data_byte[7:0], final_byte               valid && ready
// out_ch    out  out_char[6:0], last_of_run, end_of_text  valid && ready
//
// One character leaves per cycle unless out_ch stalls or the queue is empty;
// three bytes make four characters, so a byte is taken every cycle while the
// group queue has room and the back-end serializer sets the sustained rate.
// A completed group is queued, then its characters enter the output register.
// Reset is synchronous and empties the byte hold, the queue and the output.
// A stalled output holds its register; once the queue fills, in_ch.ready drops.
module base64_encode_bytes_unit #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);
  import b64e_pkg::*;

  logic    push, pop;
  grp_t    push_grp, head;
  q_stat_t q_stat;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  b64e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/b64e_stream_checker.sv =====
// Watches both channels of the encoder, predicts the characters that each
// accepted byte must produce and compares them in order with what leaves.
module b64e_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if         in_ch,
  b64e_out_if        out_ch,
  output int         mismatch_count,
  output int         chars_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  // One expected character with its two flags.
  typedef struct packed {
    char_t ch;
    logic  last_of_run;
    logic  end_of_text;
  } enc_char_t;

  // Standard alphabet packed into a vector, first character in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   expected_chars[$];
  enc_char_t   want;
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  initial begin
    mismatch_count    = 0;
    chars_outstanding = 0;
  end

  function automatic char_t alphabet_char(input logic [5:0] sextet);
    int idx;
    idx = 63 - int'(sextet);
    return ALPHABET[8*idx +: CHAR_W];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Updates the byte hold and queues the characters that this byte emits.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    char_t      group[4];
    logic [7:0] b0;
    logic [7:0] b1;
    enc_char_t  item;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    if (held_count == HELD_TWO) begin
      // A third byte completes the group; no padding even if it is final.
      group[0] = alphabet_char(b0[7:2]);
      group[1] = alphabet_char({b0[1:0], b1[7:4]});
      group[2] = alphabet_char({b1[3:0], b[7:6]});
      group[3] = alphabet_char(b[5:0]);
    end else if (!fin) begin
      // A pending byte is only stored.
      if (held_count == HELD_ONE) begin
        held_bytes[7:0] = b;
        held_count      = HELD_TWO;
      end else begin
        held_bytes = {b, 8'h00};
        held_count = HELD_ONE;
      end
      return;
    end else if (held_count == HELD_ONE) begin
      // Two-byte tail, one pad character.
      group[0] = alphabet_char(b0[7:2]);
      group[1] = alphabet_char({b0[1:0], b[7:4]});
      group[2] = alphabet_char({b[3:0], 2'b00});
      group[3] = PAD_CHAR;
    end else begin
      // One-byte tail, two pad characters.
      group[0] = alphabet_char(b[7:2]);
      group[1] = alphabet_char({b[1:0], 4'b0000});
      group[2] = PAD_CHAR;
      group[3] = PAD_CHAR;
    end
    for (int k = 0; k < 4; k++) begin
      item.ch          = group[k];
      item.last_of_run = (k == 3);
      item.end_of_text = (k == 3) && fin;
      expected_chars.push_back(item);
    end
    held_bytes = 16'h0000;
    held_count = HELD_NONE;
  endtask

  // Outgoing transfers are checked before the incoming byte is predicted;
  // a byte cannot show up at the output on the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_bytes = 16'h0000;
      held_count = HELD_NONE;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", out_ch.out_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want.ch)
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      out_ch.out_char, want.ch));
          if (out_ch.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      out_ch.last_of_run, want.last_of_run));
          if (out_ch.end_of_text !== want.end_of_text)
            report_mismatch($sformatf("end_of_text %b, expected %b",
                                      out_ch.end_of_text, want.end_of_text));
        end
      end
      if (in_ch.valid && in_ch.ready)
        encode_byte(in_ch.data_byte, in_ch.final_byte);
    end
    chars_outstanding <= expected_chars.size();
  end

endmodule

// ===== sim/base64_encode_bytes_unit_test.sv =====
// Drives byte messages into the encoder under random idling on both sides,
// with one long output stall and two full drains, and gives the verdict.
module base64_encode_bytes_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT       = 60000;
  localparam int LONG_STALL_CYCLES = 80;
  localparam int DRAIN_CYCLES      = 10;
  localparam int NUM_DIRECTED      = 22;

  // Directed messages: one-byte and two-byte tails at the byte extremes,
  // full groups of all ones and all zeros, the '+' and '/' symbols, and a
  // longer message that crosses a group boundary before its tail.
  localparam logic [7:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'hFB, 8'hEF, 8'hBE, 8'h4D, 8'h61, 8'h6E,
    8'h53, 8'h75, 8'h72, 8'h65
  };
  localparam logic DIRECTED_FINAL [NUM_DIRECTED] = '{
    1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int mismatches;
  int outstanding;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit long_stall_req = 1'b0;

  always #6 clk = ~clk;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_encode_bytes_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b64e_stream_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .mismatch_count    (mismatches),
    .chars_outstanding (outstanding)
  );

  // Offers one byte, sometimes after a short gap, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Mostly short messages, now and then a longer one.
  task automatic send_message();
    int len;
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(10, 24);
    else
      len = $urandom_range(1, 7);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Stops offering and waits until every predicted character has arrived.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Receiver: random short stalls, or one long stall on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        hold_left      = LONG_STALL_CYCLES;
        long_stall_req = 1'b0;
      end else if (hold_left == 0 && receiver_idles && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_byte(DIRECTED_BYTES[i], DIRECTED_FINAL[i]);

    while (bytes_sent < 120)
      send_message();

    // Long output stall while the sender keeps offering, so the block backs up.
    long_stall_req = 1'b1;
    while (bytes_sent < 150)
      send_message();

    while (bytes_sent < 210)
      send_message();

    // Sender pause until the output has caught up completely.
    wait_results_drained();

    while (bytes_sent < 250)
      send_message();

    // Closing stretch at full rate on both sides.
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    while (bytes_sent < 310)
      send_message();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== base64_encode_bytes_unit.f =====
sv/b64e_pkg.sv
sv/b64e_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_encode_bytes_unit.sv
sim/b64e_stream_checker.sv
sim/base64_encode_bytes_unit_test.sv
